// ===== hdl/tween_easing_generator_macros.svh =====
// Assertion macros used by the tween easing generator checker
`ifndef TWEEN_EASING_GENERATOR_MACROS_SVH
`define TWEEN_EASING_GENERATOR_MACROS_SVH
// Property holding in the cycle after the antecedent
`define TEG_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
// Property holding in the same cycle as the antecedent
`define TEG_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`endif

// ===== hdl/teg_pkg.sv =====
// Shared types, curve codes and fixed-point constants of the tween easing generator
package teg_pkg;
	localparam int CW = 24;
	localparam int QW = 17;
	typedef logic signed [CW-1:0] cval_t;

	localparam cval_t ONE_Q     = 24'sd65536;
	localparam cval_t TWO_Q     = 24'sd131072;
	localparam cval_t HALF_Q    = 24'sd32768;
	localparam cval_t BACK_C1   = 24'sd111515;
	localparam cval_t BACK_C3   = 24'sd177051;
	localparam cval_t BACK_C2   = 24'sd170060;
	localparam cval_t BACK_C2P1 = 24'sd235596;
	localparam cval_t OVR_T     = 24'sd163840;
	localparam cval_t OVR_T1    = 24'sd229376;
	localparam cval_t BNC_N     = 24'sd495616;
	localparam cval_t BNC_B1    = 24'sd262144;
	localparam cval_t BNC_B2    = 24'sd524288;
	localparam cval_t BNC_B3    = 24'sd655360;
	localparam cval_t BNC_M1    = 24'sd35747;
	localparam cval_t BNC_M2    = 24'sd53620;
	localparam cval_t BNC_M3    = 24'sd62557;
	localparam cval_t BNC_O1    = 24'sd49152;
	localparam cval_t BNC_O2    = 24'sd61440;
	localparam cval_t BNC_O3    = 24'sd64512;
	localparam cval_t ZERO_Q    = 24'sd0;

	// curve codes
	localparam logic [4:0] CRV_PJUMP    = 5'd0;
	localparam logic [4:0] CRV_QUAD_IN  = 5'd1;
	localparam logic [4:0] CRV_QUAD_OUT = 5'd2;
	localparam logic [4:0] CRV_QUAD_IO  = 5'd3;
	localparam logic [4:0] CRV_OVR_IN   = 5'd4;
	localparam logic [4:0] CRV_OVR_OUT  = 5'd5;
	localparam logic [4:0] CRV_OVR_IO   = 5'd6;
	localparam logic [4:0] CRV_CUB_IN   = 5'd7;
	localparam logic [4:0] CRV_CUB_OUT  = 5'd8;
	localparam logic [4:0] CRV_CUB_IO   = 5'd9;
	localparam logic [4:0] CRV_QRT_IN   = 5'd10;
	localparam logic [4:0] CRV_QRT_OUT  = 5'd11;
	localparam logic [4:0] CRV_QRT_IO   = 5'd12;
	localparam logic [4:0] CRV_QNT_IN   = 5'd13;
	localparam logic [4:0] CRV_QNT_OUT  = 5'd14;
	localparam logic [4:0] CRV_QNT_IO   = 5'd15;
	localparam logic [4:0] CRV_BACK_IN  = 5'd16;
	localparam logic [4:0] CRV_BACK_OUT = 5'd17;
	localparam logic [4:0] CRV_BACK_IO  = 5'd18;
	localparam logic [4:0] CRV_BNC_IN   = 5'd19;
	localparam logic [4:0] CRV_BNC_OUT  = 5'd20;
	localparam logic [4:0] CRV_BNC_IO   = 5'd21;

	// register indexes
	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_DUR   = 2'd2;
	localparam logic [1:0] REG_CURVE = 2'd3;

	// multiply programme families
	localparam logic [2:0] FAM_LIN = 3'd0;
	localparam logic [2:0] FAM_PJ  = 3'd1;
	localparam logic [2:0] FAM_POW = 3'd2;
	localparam logic [2:0] FAM_OB  = 3'd3;
	localparam logic [2:0] FAM_BK  = 3'd4;
	localparam logic [2:0] FAM_BN  = 3'd5;

	// final combination of r, b and the offset
	localparam logic [3:0] PST_ADD  = 4'd0;
	localparam logic [3:0] PST_SUB  = 4'd1;
	localparam logic [3:0] PST_SHL  = 4'd2;
	localparam logic [3:0] PST_HADD = 4'd3;
	localparam logic [3:0] PST_HSUB = 4'd4;
	localparam logic [3:0] PST_OHLF = 4'd5;
	localparam logic [3:0] PST_BADD = 4'd6;
	localparam logic [3:0] PST_BSUB = 4'd7;
	localparam logic [3:0] PST_LIN  = 4'd8;
endpackage

// ===== hdl/tween_easing_generator.sv =====
// Tween interpolator: elapsed time, divider progress, easing curve and value; curve and value on one shared multiplier
//
//  channel | dir | handshake        | contents
//  s_*     | in  | tvalid / tready  | delta_ticks
//  m_*     | out | tvalid / tready  | value, finished
//  cfg_*   | in  | cfg_we           | start, end, duration, curve
//
// With a non-zero duration one word passes from acceptance to result through
// the divider state (17 quotient bits and a hand-over), prepare, the steps of
// the curve's multiply programme (0 to 4) on the single
// shared multiplier, combine, two interpolation products and the final add and
// clamp. A zero duration skips the divider.
// s_tready is high only while the sequencer is idle; a finished word waits
// in the output register, so the next word is taken while it is held.
// arst_n clears control state and the configuration registers; the datapath registers are not reset.
module tween_easing_generator #(
	parameter int VALUE_WIDTH = 32,
	parameter int TIME_WIDTH  = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [15:0]                            s_tdata,  // [15:0] delta_ticks
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((VALUE_WIDTH+7)/8)*8-1:0]       m_tdata,  // [VALUE_WIDTH-1:0] value
	output logic [0:0]                             m_tuser,  // [0] finished
	input  logic                                   cfg_we,
	input  logic [1:0]                             cfg_index,
	input  logic [((VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH)-1:0] cfg_data
);
	import teg_pkg::*;

	localparam int DW   = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int HW   = VALUE_WIDTH - 15;
	localparam int MAW  = ((VALUE_WIDTH - 15 > CW) ? VALUE_WIDTH - 15 : CW) + 1;
	localparam int PW   = MAW + CW;
	localparam int RW   = PW + 2;
	localparam int ESW  = ((TIME_WIDTH > 16) ? TIME_WIDTH : 16) + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_PREP = 4'd2;
	localparam logic [3:0] ST_MUL  = 4'd3;
	localparam logic [3:0] ST_POST = 4'd4;
	localparam logic [3:0] ST_IHI  = 4'd5;
	localparam logic [3:0] ST_ILO  = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]             state_q;
	logic [VALUE_WIDTH-1:0] start_q, end_q;
	logic [TIME_WIDTH-1:0]  dur_q, elapsed_q;
	logic [4:0]             curve_q;
	logic                   fin_q;
	logic [QW-1:0]          x_q;

	logic [2:0]  fam_q, nmul_q, mstep_q;
	logic [3:0]  post_q;
	logic [2:0]  sh_q;
	logic        wdbl_q;
	cval_t       y_q, r_q, a_q, b_q, k1_q, k2_q, off_q, f_q;
	logic signed [PW-1:0] ph_q, pl_q;

	logic [VALUE_WIDTH-1:0] out_q;
	logic                   outv_q, outfin_q;

	// accept and elapsed update
	logic                  s_acc;
	logic [ESW-1:0]        esum;
	logic [TIME_WIDTH-1:0] e_next;
	logic                  div_done;
	logic [QW-1:0]         div_quo;

	assign s_tready = state_q == ST_IDLE;
	assign s_acc    = s_tvalid && s_tready;
	assign esum     = ESW'(elapsed_q) + ESW'(s_tdata);
	assign e_next   = (esum > ESW'(dur_q)) ? dur_q : esum[TIME_WIDTH-1:0];

	teg_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_acc && (dur_q != '0)),
		.num    (e_next),
		.den    (dur_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// curve set-up from progress
	cval_t      xs, z, z11, bcen, boff;
	logic       half;
	cval_t      p_y, p_k1, p_k2, p_off;
	logic [2:0] p_fam, p_nmul;
	logic [3:0] p_post;
	logic [2:0] p_sh;
	logic       p_wdbl;

	assign xs   = cval_t'({1'b0, x_q});
	assign half = xs < HALF_Q;

	always_comb begin
		unique case (curve_q)
			CRV_BNC_IN:  z = ONE_Q - xs;
			CRV_BNC_OUT: z = xs;
			default:     z = half ? (ONE_Q - (xs <<< 1)) : ((xs <<< 1) - ONE_Q);
		endcase
		z11 = (z <<< 3) + (z <<< 1) + z;
		priority if (z11 < BNC_B1) begin
			bcen = ZERO_Q;
			boff = ZERO_Q;
		end else if (z11 < BNC_B2) begin
			bcen = BNC_M1;
			boff = BNC_O1;
		end else if (z11 < BNC_B3) begin
			bcen = BNC_M2;
			boff = BNC_O2;
		end else begin
			bcen = BNC_M3;
			boff = BNC_O3;
		end
	end

	always_comb begin
		p_fam  = FAM_LIN;
		p_nmul = 3'd0;
		p_y    = xs;
		p_k1   = OVR_T1;
		p_k2   = ZERO_Q;
		p_off  = ZERO_Q;
		p_post = PST_ADD;
		p_sh   = 3'd0;
		p_wdbl = 1'b0;
		unique case (curve_q)
			CRV_PJUMP: begin
				p_fam  = FAM_PJ;
				p_nmul = 3'd1;
			end
			CRV_QUAD_IN, CRV_CUB_IN, CRV_QRT_IN, CRV_QNT_IN,
			CRV_QUAD_OUT, CRV_CUB_OUT, CRV_QRT_OUT, CRV_QNT_OUT,
			CRV_QUAD_IO, CRV_CUB_IO, CRV_QRT_IO, CRV_QNT_IO: begin
				p_fam = FAM_POW;
				if (curve_q <= CRV_QUAD_IO) begin
					p_nmul = 3'd1;
				end else if (curve_q <= CRV_CUB_IO) begin
					p_nmul = 3'd2;
				end else if (curve_q <= CRV_QRT_IO) begin
					p_nmul = 3'd3;
				end else begin
					p_nmul = 3'd4;
				end
				p_sh = p_nmul;
				if (curve_q == CRV_QUAD_OUT || curve_q == CRV_CUB_OUT ||
				    curve_q == CRV_QRT_OUT || curve_q == CRV_QNT_OUT) begin
					p_y    = ONE_Q - xs;
					p_post = PST_SUB;
					p_off  = ONE_Q;
				end else if (curve_q == CRV_QUAD_IO || curve_q == CRV_CUB_IO ||
				             curve_q == CRV_QRT_IO || curve_q == CRV_QNT_IO) begin
					if (half) begin
						p_post = PST_SHL;
					end else begin
						p_y    = (ONE_Q - xs) <<< 1;
						p_post = PST_OHLF;
						p_off  = ONE_Q;
					end
				end
			end
			CRV_OVR_IN: begin
				p_fam  = FAM_OB;
				p_nmul = 3'd3;
				p_k2   = -OVR_T;
			end
			CRV_OVR_OUT: begin
				p_fam  = FAM_OB;
				p_nmul = 3'd3;
				p_y    = xs - ONE_Q;
				p_k2   = OVR_T;
				p_off  = ONE_Q;
			end
			CRV_OVR_IO: begin
				p_fam  = FAM_OB;
				p_nmul = 3'd3;
				p_post = PST_HADD;
				if (half) begin
					p_wdbl = 1'b1;
					p_k2   = -OVR_T;
				end else begin
					p_y   = (xs <<< 1) - TWO_Q;
					p_k2  = OVR_T;
					p_off = TWO_Q;
				end
			end
			CRV_BACK_IN: begin
				p_fam  = FAM_BK;
				p_nmul = 3'd4;
				p_post = PST_BSUB;
			end
			CRV_BACK_OUT: begin
				p_fam  = FAM_BK;
				p_nmul = 3'd4;
				p_y    = xs - ONE_Q;
				p_post = PST_BADD;
				p_off  = ONE_Q;
			end
			CRV_BACK_IO: begin
				p_fam  = FAM_OB;
				p_nmul = 3'd3;
				p_k1   = BACK_C2P1;
				p_post = PST_HADD;
				if (half) begin
					p_y  = xs <<< 1;
					p_k2 = -BACK_C2;
				end else begin
					p_y   = (xs <<< 1) - TWO_Q;
					p_k2  = BACK_C2;
					p_off = TWO_Q;
				end
			end
			CRV_BNC_IN, CRV_BNC_OUT, CRV_BNC_IO: begin
				p_fam  = FAM_BN;
				p_nmul = 3'd2;
				p_y    = z - bcen;
				if (curve_q == CRV_BNC_IN) begin
					p_post = PST_SUB;
					p_off  = ONE_Q - boff;
				end else if (curve_q == CRV_BNC_OUT) begin
					p_off = boff;
				end else if (half) begin
					p_post = PST_HSUB;
					p_off  = ONE_Q - boff;
				end else begin
					p_post = PST_HADD;
					p_off  = ONE_Q + boff;
				end
			end
			default: begin
				p_post = PST_LIN;
			end
		endcase
	end

	// shared multiplier
	logic signed [MAW-1:0] ma;
	logic signed [CW-1:0]  mb;
	logic signed [PW-1:0]  prod;
	cval_t                 qm;
	logic [1:0]            mdst;  // 0 r, 1 a, 2 b
	cval_t                 wop;

	localparam logic [1:0] DST_R = 2'd0;
	localparam logic [1:0] DST_A = 2'd1;
	localparam logic [1:0] DST_B = 2'd2;

	logic signed [VALUE_WIDTH:0] diff;
	assign diff = {end_q[VALUE_WIDTH-1], end_q} - {start_q[VALUE_WIDTH-1], start_q};

	function automatic logic signed [MAW-1:0] cext(input cval_t v);
		cext = {{(MAW-CW){v[CW-1]}}, v};
	endfunction

	assign wop = wdbl_q ? (y_q <<< 1) : y_q;

	always_comb begin
		ma   = cext(y_q);
		mb   = y_q;
		mdst = DST_R;
		unique case (state_q)
			ST_IHI: begin
				// end - start, upper part
				ma = {{(MAW-HW){diff[VALUE_WIDTH]}}, diff[VALUE_WIDTH:16]};
				mb = f_q;
			end
			ST_ILO: begin
				ma = {{(MAW-16){1'b0}}, diff[15:0]};
				mb = f_q;
			end
			ST_MUL: begin
				unique case (fam_q)
					FAM_PJ: begin
						ma = cext(y_q <<< 2);
						mb = ONE_Q - y_q;
					end
					FAM_POW: begin
						ma = cext(r_q);
					end
					FAM_OB: begin
						unique case (mstep_q)
							3'd0: mdst = DST_A;
							3'd1: begin
								ma   = cext(k1_q);
								mb   = wop;
								mdst = DST_B;
							end
							default: begin
								ma = cext(a_q);
								mb = b_q + k2_q;
							end
						endcase
					end
					FAM_BK: begin
						unique case (mstep_q)
							3'd0: mdst = DST_A;
							3'd1: ma = cext(a_q);
							3'd2: begin
								ma   = cext(BACK_C3);
								mb   = r_q;
								mdst = DST_B;
							end
							default: begin
								ma = cext(BACK_C1);
								mb = a_q;
							end
						endcase
					end
					FAM_BN: begin
						if (mstep_q == 3'd0) begin
							mdst = DST_A;
						end else begin
							ma = cext(BNC_N);
							mb = a_q;
						end
					end
					default: begin
						ma = cext(y_q);
					end
				endcase
			end
			default: begin
				ma = cext(y_q);
			end
		endcase
	end

	assign prod = PW'(ma) * PW'(mb);
	assign qm   = prod[16+CW-1:16];

	// combine into the easing factor
	cval_t ftmp, rsum;
	always_comb begin
		rsum = r_q + off_q;
		unique case (post_q)
			PST_ADD:  ftmp = rsum;
			PST_SUB:  ftmp = off_q - r_q;
			PST_SHL:  ftmp = r_q <<< sh_q;
			PST_HADD: ftmp = rsum >>> 1;
			PST_HSUB: ftmp = (off_q - r_q) >>> 1;
			PST_OHLF: ftmp = off_q - (r_q >>> 1);
			PST_BADD: ftmp = off_q + b_q + r_q;
			PST_BSUB: ftmp = b_q - r_q;
			default:  ftmp = xs;
		endcase
	end

	// final sum and clamp
	logic signed [RW-1:0] rsat_in;
	logic signed [RW-1:0] vmax, vmin;
	logic [VALUE_WIDTH-1:0] rsat;
	assign vmax    = {{(RW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
	assign vmin    = {{(RW-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};
	assign rsat_in = {{(RW-VALUE_WIDTH){start_q[VALUE_WIDTH-1]}}, start_q}
	               + {{2{ph_q[PW-1]}}, ph_q} + {{2{pl_q[PW-1]}}, pl_q};
	always_comb begin
		priority if (rsat_in > vmax) begin
			rsat = vmax[VALUE_WIDTH-1:0];
		end else if (rsat_in < vmin) begin
			rsat = vmin[VALUE_WIDTH-1:0];
		end else begin
			rsat = rsat_in[VALUE_WIDTH-1:0];
		end
	end

	logic out_free;
	logic load_out;
	assign out_free = !outv_q || m_tready;
	assign load_out = (state_q == ST_FIN || state_q == ST_DONE) && out_free;

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= '0;
			end_q     <= '0;
			dur_q     <= '0;
			curve_q   <= '0;
			elapsed_q <= '0;
			mstep_q   <= '0;
			outv_q    <= 1'b0;
		end else begin
			if (load_out) begin
				outv_q <= 1'b1;
			end else if (m_tready) begin
				outv_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START: start_q <= cfg_data[VALUE_WIDTH-1:0];
					REG_END:   end_q   <= cfg_data[VALUE_WIDTH-1:0];
					REG_DUR:   dur_q   <= cfg_data[TIME_WIDTH-1:0];
					REG_CURVE: curve_q <= cfg_data[4:0];
				endcase
				elapsed_q <= '0;
			end else if (s_acc) begin
				elapsed_q <= e_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= (dur_q == '0) ? ST_PREP : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					mstep_q <= '0;
					state_q <= (p_nmul == 3'd0) ? ST_POST : ST_MUL;
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == nmul_q - 1'b1) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: state_q <= ST_IHI;
				ST_IHI:  state_q <= ST_ILO;
				ST_ILO:  state_q <= ST_FIN;
				ST_FIN, ST_DONE: begin
					state_q <= out_free ? ST_IDLE : ST_DONE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			fin_q <= e_next == dur_q;
			if (dur_q == '0) begin
				x_q <= QW'(ONE_Q);
			end
		end
		if (state_q == ST_DIV && div_done) begin
			x_q <= div_quo;
		end
		if (state_q == ST_PREP) begin
			fam_q  <= p_fam;
			nmul_q <= p_nmul;
			y_q    <= p_y;
			r_q    <= p_y;
			k1_q   <= p_k1;
			k2_q   <= p_k2;
			off_q  <= p_off;
			post_q <= p_post;
			sh_q   <= p_sh;
			wdbl_q <= p_wdbl;
		end
		if (state_q == ST_MUL) begin
			unique case (mdst)
				DST_A:   a_q <= qm;
				DST_B:   b_q <= qm;
				default: r_q <= qm;
			endcase
		end
		if (state_q == ST_POST) begin
			f_q <= ftmp;
		end
		if (state_q == ST_IHI) begin
			ph_q <= prod;
		end
		if (state_q == ST_ILO) begin
			pl_q <= prod >>> 16;
		end
		if (load_out) begin
			out_q    <= rsat;
			outfin_q <= fin_q;
		end
	end

	assign m_tvalid = outv_q;
	assign m_tdata  = DW'(out_q);
	assign m_tuser  = outfin_q;
endmodule

// ===== hdl/teg_div.sv =====
// Restoring divider forming the Q1.16 progress, one quotient bit a cycle
module teg_div #(
	parameter int TIME_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [TIME_WIDTH-1:0]         num,
	input  logic [TIME_WIDTH-1:0]         den,
	output logic                          done,
	output logic [teg_pkg::QW-1:0]        quo
);
	import teg_pkg::*;

	localparam int CNT_W = $clog2(QW);

	logic [TIME_WIDTH:0]   rem_q;
	logic [TIME_WIDTH-1:0] den_q;
	logic [QW-1:0]         quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [TIME_WIDTH:0]   trial;
	logic                  ge;

	// the numerator is num * 2^16 and num <= den, so the first step needs no shift
	assign trial = (cnt_q == '0) ? rem_q : {rem_q[TIME_WIDTH-1:0], 1'b0};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== hdl/teg_checker.sv =====
// Port-level checker of the tween easing generator and its bind
`include "tween_easing_generator_macros.svh"
module teg_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [((VALUE_WIDTH+7)/8)*8-1:0]       m_tdata,
	input logic [0:0]                             m_tuser
);
	`TEG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
	`TEG_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "took a second word while busy")
	`TEG_ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared too early")
	`TEG_ASSERT_SAME(a_result_frees_input, clk, arst_n, $rose(m_tvalid), s_tready, "result shown while sequencer still busy")
endmodule

bind tween_easing_generator teg_checker #(
	.VALUE_WIDTH (VALUE_WIDTH)
) u_teg_checker (.*);

// ===== sim/tb_tween_easing_generator.sv =====
// Self-checking testbench for the tween easing generator: random tweens over all curves
`timescale 1ns / 1ps

import teg_pkg::*;

class tween_scoreboard;
	typedef struct {
		logic [31:0] value;
		logic        finished;
	} tween_out_t;

	logic [31:0] start_q, end_q;
	logic [23:0] dur;
	logic [4:0]  curve;
	logic [23:0] elapsed;
	tween_out_t  pending_q[$];
	int          mismatches;

	function new();
		start_q = '0; end_q = '0; dur = '0; curve = '0; elapsed = '0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			REG_START: start_q = data;
			REG_END:   end_q = data;
			REG_DUR:   dur = data[23:0];
			REG_CURVE: curve = data[4:0];
		endcase
		elapsed = '0;
	endfunction

	function longint qm(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function longint qpow(longint x, int n);
		longint r;
		r = x;
		for (int i = 1; i < n; i++) r = qm(r, x);
		return r;
	endfunction

	function longint bounce_out(longint x);
		longint y;
		if (11 * x < 4 * longint'(ONE_Q)) return qm(BNC_N, qm(x, x));
		if (11 * x < 8 * longint'(ONE_Q)) begin
			y = x - BNC_M1;
			return qm(BNC_N, qm(y, y)) + BNC_O1;
		end
		if (11 * x < 10 * longint'(ONE_Q)) begin
			y = x - BNC_M2;
			return qm(BNC_N, qm(y, y)) + BNC_O2;
		end
		y = x - BNC_M3;
		return qm(BNC_N, qm(y, y)) + BNC_O3;
	endfunction

	// form: 0 in, 1 out, 2 in-out
	function longint power_ease(longint x, int n, int form);
		longint u;
		u = ONE_Q - x;
		if (form == 0) return qpow(x, n);
		if (form == 1) return ONE_Q - qpow(u, n);
		if (x < HALF_Q) return (longint'(1) << (n - 1)) * qpow(x, n);
		return ONE_Q - (qpow(2 * u, n) >>> 1);
	endfunction

	function longint ease_factor(longint x, logic [4:0] c);
		longint y;
		case (c)
			CRV_PJUMP: return qm(4 * x, ONE_Q - x);
			CRV_QUAD_IN, CRV_QUAD_OUT, CRV_QUAD_IO: return power_ease(x, 2, c - CRV_QUAD_IN);
			CRV_OVR_IN: return qm(qm(x, x), qm(OVR_T1, x) - OVR_T);
			CRV_OVR_OUT: begin
				y = x - ONE_Q;
				return qm(qm(y, y), qm(OVR_T1, y) + OVR_T) + ONE_Q;
			end
			CRV_OVR_IO: begin
				if (x < HALF_Q)
					return qm(qm(x, x), qm(OVR_T1, 2 * x) - OVR_T) >>> 1;
				y = 2 * x - 2 * longint'(ONE_Q);
				return (qm(qm(y, y), qm(OVR_T1, y) + OVR_T) >>> 1) + ONE_Q;
			end
			CRV_CUB_IN, CRV_CUB_OUT, CRV_CUB_IO: return power_ease(x, 3, c - CRV_CUB_IN);
			CRV_QRT_IN, CRV_QRT_OUT, CRV_QRT_IO: return power_ease(x, 4, c - CRV_QRT_IN);
			CRV_QNT_IN, CRV_QNT_OUT, CRV_QNT_IO: return power_ease(x, 5, c - CRV_QNT_IN);
			CRV_BACK_IN: return qm(BACK_C3, qpow(x, 3)) - qm(BACK_C1, qpow(x, 2));
			CRV_BACK_OUT: begin
				y = x - ONE_Q;
				return ONE_Q + qm(BACK_C3, qpow(y, 3)) + qm(BACK_C1, qpow(y, 2));
			end
			CRV_BACK_IO: begin
				if (x < HALF_Q) begin
					y = 2 * x;
					return qm(qm(y, y), qm(BACK_C2P1, y) - BACK_C2) >>> 1;
				end
				y = 2 * x - 2 * longint'(ONE_Q);
				return (qm(qm(y, y), qm(BACK_C2P1, y) + BACK_C2) + 2 * longint'(ONE_Q)) >>> 1;
			end
			CRV_BNC_IN: return ONE_Q - bounce_out(ONE_Q - x);
			CRV_BNC_OUT: return bounce_out(x);
			CRV_BNC_IO: begin
				if (x < HALF_Q) return (ONE_Q - bounce_out(ONE_Q - 2 * x)) >>> 1;
				return (ONE_Q + bounce_out(2 * x - ONE_Q)) >>> 1;
			end
			default: return x;
		endcase
	endfunction

	function void note_step(logic [15:0] delta);
		longint el, prog, f, s, e, diff, hi, lo, r;
		tween_out_t o;
		el = longint'(elapsed) + delta;
		if (el > dur) el = dur;
		elapsed = el[23:0];
		prog = (dur == 0) ? longint'(ONE_Q) : (el << 16) / dur;
		f = ease_factor(prog, curve);
		s = longint'(signed'(start_q));
		e = longint'(signed'(end_q));
		diff = e - s;
		hi = diff >>> 16;
		lo = diff - hi * 65536;
		r = s + hi * f + ((lo * f) >>> 16);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		o.value = r[31:0];
		o.finished = (elapsed >= dur);
		pending_q.push_back(o);
	endfunction

	function void check_result(logic [31:0] value, logic finished);
		tween_out_t o;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected word: value %h finished %b", value, finished);
			return;
		end
		o = pending_q.pop_front();
		if (o.value !== value || o.finished !== finished) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected value %h finished %b, got value %h finished %b",
					o.value, o.finished, value, finished);
		end
	endfunction
endclass

module tb_tween_easing_generator;
	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tween_scoreboard sb = new();
	int src_idle = 0;
	int sink_stall = 0;
	int hold_cycles = 0;
	int quiet = 0;

	tween_easing_generator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready = 1'b0;
		end else m_tready = ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_step(s_tdata);
		if (m_tvalid && m_tready) sb.check_result(m_tdata[31:0], m_tuser[0]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) quiet = 0;
		else quiet++;
		if (quiet == WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// called and returns at a falling edge
	task automatic send_word(logic [15:0] d);
		s_tvalid = 1'b0;
		while ($urandom_range(99) < src_idle) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_tween(logic [31:0] s, logic [31:0] e, logic [23:0] d, logic [4:0] c);
		wait_idle();
		write_reg(REG_START, s);
		write_reg(REG_END, e);
		write_reg(REG_DUR, {8'd0, d});
		write_reg(REG_CURVE, {27'd0, c});
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom_range(2000000) - 1000000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_tween(int steps);
		logic [23:0] d;
		int span;
		case ($urandom_range(9))
			0: d = 24'd0;
			1: d = 24'hffffff;
			2: d = $urandom;
			default: d = $urandom_range(1, 3000);
		endcase
		set_tween(pick_value(), pick_value(), d, $urandom_range(31));
		// spread the steps over the tween so every curve segment is visited
		span = (d == 0) ? 1 : d / steps + 1;
		if (span > 65535) span = 65535;
		for (int i = 0; i < steps; i++) begin
			case ($urandom_range(9))
				0: send_word($urandom);
				1: send_word(16'd0);
				2: send_word(16'hffff);
				default: send_word($urandom_range(span));
			endcase
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero duration after reset, extremes of both end values
		send_word(16'd0);
		set_tween(32'h8000_0000, 32'h7fff_ffff, 24'd0, CRV_BNC_IO);
		send_word(16'hffff);
		set_tween(32'h7fff_ffff, 32'h8000_0000, 24'hffffff, CRV_OVR_OUT);
		send_word(16'hffff);
		send_word(16'h0);
		// overshoot past the end: clamped at the duration
		set_tween(32'h0001_0000, 32'hffff_0000, 24'd100, CRV_BACK_OUT);
		send_word(16'd50);
		send_word(16'hffff);
		// overshoot curves saturate with extreme endpoints
		set_tween(32'h8000_0000, 32'h7fff_ffff, 24'd10, CRV_BACK_IO);
		send_word(16'd2);
		send_word(16'd7);
		// every third curve code, including some unused linear ones, at its midpoint
		for (int c = 0; c < 32; c += 3) begin
			set_tween(32'h0, 32'h0064_0000, 24'd64, c);
			send_word(16'd32);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 86; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 86; end
				default: begin src_idle = 17; sink_stall = 17; end
			endcase
			if (ph == 0) begin
				// hold the output off so the block fills and refuses new words
				wait_idle();
				hold_cycles = 400;
				for (int i = 0; i < 6; i++) send_word($urandom_range(100));
			end
			for (int t = 0; t < 10; t++) random_tween($urandom_range(6, 14));
		end

		src_idle = 0;
		sink_stall = 0;
		wait_idle();
		if (sb.pending_q.size() == 0 && sb.mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
